// ===== rtl/sbe_pkg.sv =====
// Package for the stack bytecode executor: opcode codes, command and status types,
// and the address wrap helpers used by the front decoder and the back end.
// No dependencies.
package sbe_pkg;

  localparam int WORD_W          = 32;
  localparam int IP_W            = 8;
  localparam int DEPTH_W         = 9;
  localparam int CODE_DEPTH      = 256;
  localparam int STACK_DEPTH_DEF = 256;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0] OP_HALT  = 8'h00;
  localparam logic [7:0] OP_EMIT  = 8'h01;
  localparam logic [7:0] OP_ADD   = 8'h02;
  localparam logic [7:0] OP_SUB   = 8'h03;
  localparam logic [7:0] OP_MUL   = 8'h04;
  localparam logic [7:0] OP_LOAD  = 8'h06;
  localparam logic [7:0] OP_PUSH  = 8'h07;
  localparam logic [7:0] OP_POP   = 8'h08;
  localparam logic [7:0] OP_JMP   = 8'h09;
  localparam logic [7:0] OP_JZ    = 8'h0A;
  localparam logic [7:0] OP_JNZ   = 8'h0B;
  localparam logic [7:0] OP_READ  = 8'h0C;

  typedef enum logic [3:0] {
    K_HALT, K_PRINT, K_ADD, K_SUB, K_MUL, K_LIT, K_POP,
    K_JMP, K_JZ, K_JNZ, K_INPUT, K_BAD
  } kind_t;

  typedef enum logic [1:0] {
    ST_RUN, ST_HALT, ST_BADOP, ST_STACKERR
  } status_t;

  typedef enum logic {
    BK_ISSUE, BK_FINISH
  } bk_state_t;

  typedef struct packed {
    kind_t             kind;
    logic [1:0]        need_pop;
    logic              push;
    logic [7:0]        operand;
    logic [IP_W-1:0]   target;
    logic [WORD_W-1:0] value;
  } cmd_t;

  // Reduces an 8-bit code address modulo CODE_DEPTH by restoring subtraction.
  // The quotient fits in four bits because CODE_DEPTH is at least 16.
  function automatic logic [IP_W-1:0] wrap_target(input logic [7:0] a);
    logic [11:0] r;
    r = {4'd0, a};
    for (int k = 3; k >= 0; k--) begin
      if (r >= (12'(CODE_DEPTH) << k)) begin
        r = r - (12'(CODE_DEPTH) << k);
      end
    end
    return r[IP_W-1:0];
  endfunction

  // Advances the instruction pointer by one or two and wraps it.
  function automatic logic [IP_W-1:0] ip_step(input logic [IP_W-1:0] ip, input logic two);
    logic [IP_W:0] s;
    s = {1'b0, ip} + (two ? (IP_W+1)'(2) : (IP_W+1)'(1));
    if (s >= (IP_W+1)'(CODE_DEPTH)) begin
      s = s - (IP_W+1)'(CODE_DEPTH);
    end
    return s[IP_W-1:0];
  endfunction

endpackage

// ===== rtl/stack_bytecode_executor.sv =====
// Top level of the stack bytecode executor: front decoder, command queue and back end.
// Depends on sbe_pkg, sbe_front, sbe_queue and sbe_back.
//
//   channel  direction  handshake          payload
//   in       request    in_valid/in_stall  op, operand, input_value
//   out      result     out_valid/out_stall next_ip, status, print_valid, print_value,
//                                          stack_depth
//
// Requests that push, jump, halt or fault commit from the issue state; one that pops
// (PRINT, POP, JZ, JNZ, ADD, SUB, MUL) first reads the entry below the cached top of
// stack via a registered read of the one-port memory, then commits in the finish state.
// Reset (rst, synchronous) clears the pointer, stack count, stop status, queue and
// result valid flag; the stack memory is not cleared and needs no clearing pass.
// in_stall rises only when the two-entry queue is full; out_stall holds the result
// register, and the back end waits on it while the front keeps filling the queue.
module stack_bytecode_executor #(
  parameter int STACK_DEPTH = sbe_pkg::STACK_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         op,
  input  logic [7:0]                         operand,
  input  logic signed [sbe_pkg::WORD_W-1:0]  input_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [sbe_pkg::IP_W-1:0]           next_ip,
  output logic [1:0]                         status,
  output logic                               print_valid,
  output logic signed [sbe_pkg::WORD_W-1:0]  print_value,
  output logic [sbe_pkg::DEPTH_W-1:0]        stack_depth
);
  import sbe_pkg::*;

  cmd_t              front_cmd;
  cmd_t              head_cmd;
  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_not_empty;
  logic [WORD_W-1:0] print_bits;

  // The front end decodes each request and precomputes the wrapped jump target.
  sbe_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .operand     (operand),
    .input_value (input_value),
    .q_full      (q_full),
    .q_push      (q_push),
    .cmd         (front_cmd)
  );

  // The queue lets the front take requests while the back end waits on the result.
  sbe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_cmd    (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rd_cmd    (head_cmd)
  );

  // The back end owns all architectural state and the result register.
  sbe_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (q_not_empty),
    .cmd         (head_cmd),
    .cmd_take    (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .next_ip     (next_ip),
    .status      (status),
    .print_valid (print_valid),
    .print_value (print_bits),
    .stack_depth (stack_depth)
  );

  assign print_value = $signed(print_bits);

endmodule

// ===== rtl/sbe_front.sv =====
// Front end: accepts requests and classifies each opcode into a command.
// Depends on sbe_pkg.
module sbe_front (
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                op,
  input  logic [7:0]                operand,
  input  logic [sbe_pkg::WORD_W-1:0] input_value,
  input  logic                      q_full,
  output logic                      q_push,
  output sbe_pkg::cmd_t             cmd
);
  import sbe_pkg::*;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    cmd.kind     = K_BAD;
    cmd.need_pop = 2'd0;
    cmd.push     = 1'b0;
    cmd.operand  = operand;
    cmd.target   = wrap_target(operand);
    cmd.value    = input_value;
    case (op)
      OP_HALT:  cmd.kind = K_HALT;
      OP_EMIT:  begin cmd.kind = K_PRINT; cmd.need_pop = 2'd1; end
      OP_ADD:   begin cmd.kind = K_ADD; cmd.need_pop = 2'd2; cmd.push = 1'b1; end
      OP_SUB:   begin cmd.kind = K_SUB; cmd.need_pop = 2'd2; cmd.push = 1'b1; end
      OP_MUL:   begin cmd.kind = K_MUL; cmd.need_pop = 2'd2; cmd.push = 1'b1; end
      OP_LOAD:  begin cmd.kind = K_LIT; cmd.push = 1'b1; end
      OP_PUSH:  begin cmd.kind = K_LIT; cmd.push = 1'b1; end
      OP_POP:   begin cmd.kind = K_POP; cmd.need_pop = 2'd1; end
      OP_JMP:   cmd.kind = K_JMP;
      OP_JZ:    begin cmd.kind = K_JZ; cmd.need_pop = 2'd1; end
      OP_JNZ:   begin cmd.kind = K_JNZ; cmd.need_pop = 2'd1; end
      OP_READ:  begin cmd.kind = K_INPUT; cmd.push = 1'b1; end
      default:  cmd.kind = K_BAD;
    endcase
  end

endmodule

// ===== rtl/sbe_queue.sv =====
// Two-entry command queue between the front decoder and the back end.
// Depends on sbe_pkg.
module sbe_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sbe_pkg::cmd_t wr_cmd,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output sbe_pkg::cmd_t rd_cmd
);
  import sbe_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign rd_cmd    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

endmodule

// ===== rtl/sbe_back.sv =====
// Back end: executes commands against the stack, with the top entry cached in a
// register and the rest in a one-port memory; drives the result register. Uses sbe_pkg.
module sbe_back #(
  parameter int STACK_DEPTH = sbe_pkg::STACK_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  input  sbe_pkg::cmd_t               cmd,
  output logic                        cmd_take,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sbe_pkg::IP_W-1:0]    next_ip,
  output logic [1:0]                  status,
  output logic                        print_valid,
  output logic [sbe_pkg::WORD_W-1:0]  print_value,
  output logic [sbe_pkg::DEPTH_W-1:0] stack_depth
);
  import sbe_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [WORD_W-1:0] mem [STACK_DEPTH];
  logic [WORD_W-1:0] rd_data;
  logic [WORD_W-1:0] tos;
  logic [CW-1:0]     cnt;
  logic [IP_W-1:0]   ip;
  status_t           stopped;
  bk_state_t         state;
  bk_state_t         state_next;

  logic              out_free;
  logic              stack_err;
  logic              fault;
  logic              rd_en;
  logic              commit;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic              mem_we;
  logic              tos_we;
  logic [WORD_W-1:0] tos_next;
  logic [CW-1:0]     cnt_next;
  logic [IP_W-1:0]   ip_next;
  status_t           stopped_next;
  logic              pvalid;
  logic [WORD_W-1:0] pv;
  logic [CW:0]       after_cnt;

  assign out_free  = !out_valid || !out_stall;
  assign after_cnt = {1'b0, cnt} + (CW+1)'(cmd.push) - (CW+1)'(cmd.need_pop);
  assign stack_err = (CW'(cmd.need_pop) > cnt) || (after_cnt > (CW+1)'(STACK_DEPTH));
  assign fault     = (cmd.kind == K_BAD) || (cmd.kind == K_HALT) || stack_err;
  assign rd_addr   = AW'(cnt - CW'(2));
  assign wr_addr   = AW'(cnt - CW'(1));

  // Sequencing: commands that pop need the entry below the top, read in the issue state.
  always_comb begin
    state_next = state;
    cmd_take   = 1'b0;
    rd_en      = 1'b0;
    commit     = 1'b0;
    case (state)
      BK_ISSUE: begin
        if (cmd_valid) begin
          if (stopped == ST_RUN && !fault && cmd.need_pop != 2'd0) begin
            rd_en      = 1'b1;
            state_next = BK_FINISH;
          end else if (out_free) begin
            cmd_take = 1'b1;
            commit   = 1'b1;
          end
        end
      end
      BK_FINISH: begin
        if (out_free) begin
          cmd_take   = 1'b1;
          commit     = 1'b1;
          state_next = BK_ISSUE;
        end
      end
      default: state_next = BK_ISSUE;
    endcase
  end

  // Execution of the command at the head of the queue.
  always_comb begin
    tos_next     = tos;
    tos_we       = 1'b0;
    mem_we       = 1'b0;
    cnt_next     = cnt;
    ip_next      = ip;
    stopped_next = stopped;
    pvalid       = 1'b0;
    pv           = '0;
    if (stopped != ST_RUN) begin
      ip_next = ip;
    end else if (cmd.kind == K_BAD) begin
      stopped_next = ST_BADOP;
      ip_next      = ip_step(ip, 1'b0);
    end else if (cmd.kind == K_HALT) begin
      stopped_next = ST_HALT;
      ip_next      = ip_step(ip, 1'b0);
    end else if (stack_err) begin
      stopped_next = ST_STACKERR;
      ip_next      = ip_step(ip, 1'b0);
    end else begin
      case (cmd.kind)
        K_PRINT: begin
          pvalid   = 1'b1;
          pv       = tos;
          tos_next = rd_data;
          tos_we   = 1'b1;
          cnt_next = cnt - CW'(1);
          ip_next  = ip_step(ip, 1'b0);
        end
        K_ADD, K_SUB, K_MUL: begin
          case (cmd.kind)
            K_ADD:   tos_next = rd_data + tos;
            K_SUB:   tos_next = rd_data - tos;
            default: tos_next = rd_data * tos;
          endcase
          tos_we   = 1'b1;
          cnt_next = cnt - CW'(1);
          ip_next  = ip_step(ip, 1'b0);
        end
        K_LIT, K_INPUT: begin
          tos_next = (cmd.kind == K_LIT) ? {{(WORD_W-8){1'b0}}, cmd.operand} : cmd.value;
          tos_we   = 1'b1;
          mem_we   = (cnt != '0);
          cnt_next = cnt + CW'(1);
          ip_next  = ip_step(ip, cmd.kind == K_LIT);
        end
        K_POP: begin
          tos_next = rd_data;
          tos_we   = 1'b1;
          cnt_next = cnt - CW'(1);
          ip_next  = ip_step(ip, 1'b0);
        end
        K_JMP: ip_next = cmd.target;
        K_JZ, K_JNZ: begin
          if ((tos == '0) == (cmd.kind == K_JZ)) begin
            ip_next = cmd.target;
          end else begin
            ip_next = ip_step(ip, 1'b1);
          end
          tos_next = rd_data;
          tos_we   = 1'b1;
          cnt_next = cnt - CW'(1);
        end
        default: ip_next = ip;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (commit && mem_we) begin
      mem[wr_addr] <= tos;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (commit && tos_we) begin
      tos <= tos_next;
    end
    if (commit) begin
      next_ip     <= ip_next;
      status      <= stopped_next;
      print_valid <= pvalid;
      print_value <= pv;
      stack_depth <= DEPTH_W'(cnt_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_ISSUE;
      cnt       <= '0;
      ip        <= '0;
      stopped   <= ST_RUN;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        cnt     <= cnt_next;
        ip      <= ip_next;
        stopped <= stopped_next;
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(STACK_DEPTH))
    else $error("stack count beyond stack depth");

  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    (stopped != ST_RUN) |=> $stable(stopped))
    else $error("stop status changed without reset");

  a_finish_holds: assert property (@(posedge clk) disable iff (rst)
    (state == BK_FINISH && !out_free) |=> (state == BK_FINISH && $stable(cnt)))
    else $error("pending command lost while result register is blocked");

  a_print_running: assert property (@(posedge clk) disable iff (rst)
    (out_valid && print_valid) |-> (status == ST_RUN))
    else $error("print reported with a stopped status");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for stack_bytecode_executor: a directed program, random stack
// programs, one closing stop and a tail after it, each checked against an in-bench model.
// Depends on sbe_pkg and the stack_bytecode_executor RTL.
`timescale 1ns / 1ps

module tb_top;
  import sbe_pkg::*;

  localparam int STACK_LIMIT = STACK_DEPTH_DEF;
  localparam int RANDOM_REQUESTS = 1900;
  localparam int TAIL_REQUESTS = 40;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES = 200;
  localparam int HOLD_AT_RESULT = 300;

  // Random program generator modes: roam keeps the stack shallow, climb fills it to the
  // top and drain brings it back down, so both ends of the stack get exercised.
  typedef enum {WALK_ROAM, WALK_CLIMB, WALK_DRAIN} walk_t;

  // How the run ends: a stop is sticky until reset, and reset happens only once, so
  // exactly one stopping event closes each run. The seed picks which one.
  typedef enum {END_HALT, END_BADOP, END_UNDERFLOW, END_OVERFLOW} stop_kind_t;

  // Operation classes used by the generator.
  typedef enum {CLS_PUSH, CLS_POP1, CLS_BINARY} op_class_t;

  typedef struct {
    int          idx;
    logic [7:0]  ip;
    status_t     st;
    logic        pv;
    logic [31:0] pval;
    logic [8:0]  depth;
  } step_res_t;

  typedef struct {
    logic [7:0]  code;
    logic [7:0]  arg;
    logic [31:0] word;
    bit          typed;
    step_res_t   want;
  } script_row_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [7:0]                       op = '0;
  logic [7:0]                       operand = '0;
  logic signed [WORD_W-1:0]         input_value = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [IP_W-1:0]                  next_ip;
  logic [1:0]                       status;
  logic                             print_valid;
  logic signed [WORD_W-1:0]         print_value;
  logic [DEPTH_W-1:0]               stack_depth;

  stack_bytecode_executor DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .operand(operand),
    .input_value(input_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .next_ip(next_ip),
    .status(status),
    .print_valid(print_valid),
    .print_value(print_value),
    .stack_depth(stack_depth)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Machine state as the bench sees it. It advances once per accepted request, in the
  // order the block accepts them.
  logic [7:0]  cur_ip = '0;
  logic [31:0] words [STACK_LIMIT];
  int unsigned depth_q = 0;
  status_t     halt_st = ST_RUN;

  step_res_t   pending_steps[$];
  script_row_t script[$];
  int          error_count = 0;
  int          request_count = 0;
  bit          calm = 1'b0;

  // Prints one line for each mismatch and counts it.
  task automatic report(input string what, input int idx, input logic [31:0] got,
                        input logic [31:0] want);
    error_count++;
    $display("[%0t] request %0d: %s got %0h, wanted %0h", $time, idx, what, got, want);
  endtask

  // Code addresses wrap at the size of the code store.
  function automatic logic [7:0] code_addr(input int a);
    return 8'(a % CODE_DEPTH);
  endfunction

  // Executes one instruction on the bench's copy of the machine and returns the result
  // the block should report for it.
  task automatic execute_step(input logic [7:0] code, input logic [7:0] arg,
                              input logic [31:0] word, output step_res_t r);
    int unsigned pops;
    int unsigned pushes;
    bit          known;
    logic [31:0] lhs;
    logic [31:0] rhs;
    pops = 0;
    pushes = 0;
    known = 1'b1;
    r.pv = 1'b0;
    r.pval = '0;
    if (halt_st == ST_RUN) begin
      case (code)
        OP_HALT, OP_JMP: begin
        end
        OP_EMIT, OP_POP, OP_JZ, OP_JNZ: begin
          pops = 1;
        end
        OP_ADD, OP_SUB, OP_MUL: begin
          pops = 2;
          pushes = 1;
        end
        OP_LOAD, OP_PUSH, OP_READ: begin
          pushes = 1;
        end
        default: begin
          known = 1'b0;
        end
      endcase
      // Every stop moves the pointer just past the opcode and freezes the machine.
      if (!known) begin
        halt_st = ST_BADOP;
        cur_ip = code_addr(cur_ip + 1);
      end else if (code == OP_HALT) begin
        halt_st = ST_HALT;
        cur_ip = code_addr(cur_ip + 1);
      end else if (depth_q < pops || depth_q - pops + pushes > STACK_LIMIT) begin
        halt_st = ST_STACKERR;
        cur_ip = code_addr(cur_ip + 1);
      end else begin
        case (code)
          OP_EMIT: begin
            depth_q--;
            r.pv = 1'b1;
            r.pval = words[depth_q];
            cur_ip = code_addr(cur_ip + 1);
          end
          OP_ADD, OP_SUB, OP_MUL: begin
            rhs = words[depth_q - 1];
            lhs = words[depth_q - 2];
            depth_q--;
            if (code == OP_ADD) begin
              words[depth_q - 1] = lhs + rhs;
            end else if (code == OP_SUB) begin
              words[depth_q - 1] = lhs - rhs;
            end else begin
              words[depth_q - 1] = lhs * rhs;
            end
            cur_ip = code_addr(cur_ip + 1);
          end
          OP_LOAD, OP_PUSH: begin
            words[depth_q] = {24'd0, arg};
            depth_q++;
            cur_ip = code_addr(cur_ip + 2);
          end
          OP_POP: begin
            depth_q--;
            cur_ip = code_addr(cur_ip + 1);
          end
          OP_JMP: begin
            cur_ip = code_addr(arg);
          end
          OP_JZ, OP_JNZ: begin
            depth_q--;
            if ((words[depth_q] == 32'd0) == (code == OP_JZ)) begin
              cur_ip = code_addr(arg);
            end else begin
              cur_ip = code_addr(cur_ip + 2);
            end
          end
          default: begin
            words[depth_q] = word;
            depth_q++;
            cur_ip = code_addr(cur_ip + 1);
          end
        endcase
      end
    end
    r.ip = cur_ip;
    r.st = halt_st;
    r.depth = depth_q[8:0];
  endtask

  // Offers one request after a random gap (none in calm stretches), holds it until the
  // block takes it, then records what the block must answer. A typed expectation replaces
  // the computed one but the bench's machine state still advances.
  task automatic issue_request(input logic [7:0] code, input logic [7:0] arg,
                               input logic [31:0] word, input bit typed,
                               input step_res_t want);
    int        gap;
    step_res_t r;
    gap = calm ? 0 : $urandom_range(0, 19);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    op <= code;
    operand <= arg;
    input_value <= word;
    do @(posedge clk); while (in_stall !== 1'b0);
    execute_step(code, arg, word, r);
    if (typed) begin
      r = want;
    end
    r.idx = request_count;
    request_count++;
    pending_steps.push_back(r);
  endtask

  task automatic row_chk(input logic [7:0] code, input logic [7:0] arg,
                         input logic [31:0] word, input bit typed, input logic [7:0] eip,
                         input status_t est, input logic epv, input logic [31:0] epval,
                         input logic [8:0] edepth);
    script_row_t s;
    s.code = code;
    s.arg = arg;
    s.word = word;
    s.typed = typed;
    s.want.idx = 0;
    s.want.ip = eip;
    s.want.st = est;
    s.want.pv = epv;
    s.want.pval = epval;
    s.want.depth = edepth;
    script.push_back(s);
  endtask

  task automatic row(input logic [7:0] code, input logic [7:0] arg, input logic [31:0] word);
    row_chk(code, arg, word, 1'b0, '0, ST_RUN, 1'b0, '0, '0);
  endtask

  function automatic logic [7:0] op_of(input op_class_t cls);
    int k;
    k = $urandom_range(0, 3);
    case (cls)
      CLS_PUSH: begin
        return (k == 0) ? OP_LOAD : (k == 1) ? OP_PUSH : OP_READ;
      end
      CLS_POP1: begin
        return (k == 0) ? OP_EMIT : (k == 1) ? OP_POP : (k == 2) ? OP_JZ : OP_JNZ;
      end
      default: begin
        return (k == 0) ? OP_ADD : (k == 1) ? OP_SUB : OP_MUL;
      end
    endcase
  endfunction

  // Picks a legal instruction for the current stack depth, biased by the walk mode.
  function automatic logic [7:0] pick_op(input int unsigned d, input walk_t m);
    int r;
    bit want_push;
    r = $urandom_range(0, 99);
    case (m)
      WALK_CLIMB: want_push = (r < 85);
      WALK_DRAIN: want_push = (r < 15);
      default:    want_push = (r < 45);
    endcase
    if (d == 0) begin
      want_push = (r < 80);
    end
    if (d >= STACK_LIMIT) begin
      want_push = 1'b0;
    end
    if (want_push) begin
      return op_of(CLS_PUSH);
    end
    if (d == 0 || r % 8 == 0) begin
      return OP_JMP;
    end
    if (d >= 2 && $urandom_range(0, 1) == 1) begin
      return op_of(CLS_BINARY);
    end
    return op_of(CLS_POP1);
  endfunction

  // Operands and pushed words lean on zero and the extremes, which also makes the
  // conditional jumps go both ways often.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 11))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Result side: stalls a random number of cycles before each result, except in calm
  // stretches, and once holds off for a long stretch so that the block's queue fills
  // and it has to stall the request side.
  initial begin
    int        n;
    int        taken;
    step_res_t e;
    taken = 0;
    wait (rst == 1'b0);
    forever begin
      n = calm ? 0 : $urandom_range(0, 19);
      if (taken == HOLD_AT_RESULT) begin
        n = HOLD_CYCLES;
      end
      repeat (n) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      taken++;
      if (pending_steps.size() == 0) begin
        report("unexpected result, next_ip", -1, 32'(next_ip), '0);
      end else begin
        e = pending_steps.pop_front();
        if (next_ip !== e.ip) report("next_ip", e.idx, 32'(next_ip), 32'(e.ip));
        if (status !== e.st) report("status", e.idx, 32'(status), 32'(e.st));
        if (print_valid !== e.pv) report("print_valid", e.idx, 32'(print_valid), 32'(e.pv));
        if (print_value !== e.pval) report("print_value", e.idx, print_value, e.pval);
        if (stack_depth !== e.depth) report("stack_depth", e.idx, 32'(stack_depth),
                                            32'(e.depth));
      end
    end
  end

  // Request side: reset, the directed program, random programs, one closing stop, and
  // a tail of arbitrary requests that the stopped block must ignore.
  initial begin
    step_res_t  none;
    walk_t      walk;
    stop_kind_t ending;
    logic [7:0] code;
    none = '{idx: 0, ip: '0, st: ST_RUN, pv: 1'b0, pval: '0, depth: '0};
    walk = WALK_ROAM;

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed program. It runs the arithmetic through its wrap points, takes and skips
    // both conditional jumps, and wraps the instruction pointer past the top of the
    // code store. Rows whose result is obvious carry it typed in.
    row_chk(OP_PUSH, 8'hFF, 32'h0, 1'b1, 8'h02, ST_RUN, 1'b0, 32'h0, 9'd1);
    row_chk(OP_LOAD, 8'h00, 32'h0, 1'b1, 8'h04, ST_RUN, 1'b0, 32'h0, 9'd2);
    row(OP_ADD, 8'h00, 32'h0);
    row(OP_READ, 8'h00, 32'h7FFF_FFFF);
    row(OP_ADD, 8'h00, 32'h0);
    row(OP_READ, 8'hFF, 32'h8000_0000);
    row(OP_SUB, 8'h00, 32'h0);
    row(OP_READ, 8'h00, 32'hFFFF_FFFF);
    row(OP_MUL, 8'h00, 32'h0);
    // 0xFE times minus one leaves minus 254 to print.
    row_chk(OP_EMIT, 8'h00, 32'h0, 1'b1, 8'h0C, ST_RUN, 1'b1, 32'hFFFF_FF02, 9'd0);
    row_chk(OP_JMP, 8'hFF, 32'h0, 1'b1, 8'hFF, ST_RUN, 1'b0, 32'h0, 9'd0);
    row_chk(OP_READ, 8'h00, 32'h0000_0001, 1'b1, 8'h00, ST_RUN, 1'b0, 32'h0, 9'd1);
    row(OP_JZ, 8'h40, 32'h0);
    row(OP_LOAD, 8'h00, 32'h0);
    row(OP_JZ, 8'h80, 32'h0);
    row(OP_LOAD, 8'h00, 32'h0);
    row(OP_JNZ, 8'h33, 32'h0);
    row(OP_READ, 8'h00, 32'h5A5A_5A5A);
    row(OP_JNZ, 8'hFE, 32'h0);
    row_chk(OP_PUSH, 8'h80, 32'h0, 1'b1, 8'h00, ST_RUN, 1'b0, 32'h0, 9'd1);
    row(OP_PUSH, 8'h7F, 32'h0);
    row(OP_POP, 8'h00, 32'h0);
    row_chk(OP_EMIT, 8'h00, 32'h0, 1'b1, 8'h04, ST_RUN, 1'b1, 32'h0000_0080, 9'd0);
    row(OP_JMP, 8'h00, 32'h0);
    foreach (script[i]) begin
      issue_request(script[i].code, script[i].arg, script[i].word, script[i].typed,
                    script[i].want);
    end

    // Random well-formed programs. Every few hundred requests both sides stop idling
    // for a while so back-to-back traffic is covered too.
    for (int k = 0; k < RANDOM_REQUESTS; k++) begin
      calm = (k % 400) >= 330;
      case (walk)
        WALK_ROAM: begin
          if (k == 200 || $urandom_range(0, 249) == 0) walk = WALK_CLIMB;
        end
        WALK_CLIMB: begin
          if (depth_q >= STACK_LIMIT) walk = WALK_DRAIN;
        end
        default: begin
          if (depth_q <= 2) walk = WALK_ROAM;
        end
      endcase
      issue_request(pick_op(depth_q, walk), pick_byte(), pick_word(), 1'b0, none);
    end
    calm = 1'b0;

    // The closing stop: halt, an undefined opcode, popping an empty or one-deep stack,
    // or pushing onto a full one.
    ending = stop_kind_t'($urandom_range(0, 3));
    case (ending)
      END_HALT: begin
        issue_request(OP_HALT, pick_byte(), pick_word(), 1'b0, none);
      end
      END_BADOP: begin
        code = ($urandom_range(0, 3) == 0) ? 8'h05 : 8'($urandom_range(8'h0D, 8'hFF));
        issue_request(code, pick_byte(), pick_word(), 1'b0, none);
      end
      END_UNDERFLOW: begin
        n_loop_underflow: begin
          int unsigned floor_d;
          floor_d = $urandom_range(0, 1);
          while (depth_q > floor_d) begin
            issue_request(OP_POP, pick_byte(), pick_word(), 1'b0, none);
          end
          code = (depth_q == 1) ? op_of(CLS_BINARY) : op_of(CLS_POP1);
          if (depth_q == 0 && $urandom_range(0, 1) == 1) code = op_of(CLS_BINARY);
          issue_request(code, pick_byte(), pick_word(), 1'b0, none);
        end
      end
      default: begin
        while (depth_q < STACK_LIMIT) begin
          issue_request(op_of(CLS_PUSH), pick_byte(), pick_word(), 1'b0, none);
        end
        issue_request(op_of(CLS_PUSH), pick_byte(), pick_word(), 1'b0, none);
      end
    endcase

    // Anything after a stop must leave the reported state untouched.
    for (int k = 0; k < TAIL_REQUESTS; k++) begin
      issue_request(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), $urandom(),
                    1'b0, none);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk);
    // Give a stray extra result time to show up.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #8_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

// ===== stack_bytecode_executor.f =====
rtl/sbe_pkg.sv
rtl/sbe_front.sv
rtl/sbe_queue.sv
rtl/sbe_back.sv
rtl/stack_bytecode_executor.sv
tb/sv/tb_top.sv
